@@ rtl/hpr_pkg.sv @@
// hpr_pkg: shared types and constants for the histogram percentile range block
// command and status words between hpr_ctrl and hpr_datapath
// no dependencies
`default_nettype none

package hpr_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int BIN_SHIFT    = 4;
  localparam int PCT_W        = 15;
  localparam int LIMIT_W      = 8;
  localparam int LOW_LEVEL_W  = 17;
  localparam int HIGH_LEVEL_W = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PCT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PCT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARSE   = 2'd2;

  localparam logic [PCT_W-1:0]   LOW_PCT_RST  = 15'd256;
  localparam logic [PCT_W-1:0]   HIGH_PCT_RST = 15'd256;
  localparam logic [LIMIT_W-1:0] SPARSE_RST   = 8'd10;

  // 100 percent in q7.8 is 25600 = 2^14 + 2^13 + 2^10
  localparam int SCALE_SH_A = 14;
  localparam int SCALE_SH_B = 13;
  localparam int SCALE_SH_C = 10;

  typedef enum logic [1:0] {
    RD_SAMPLE = 2'd0,
    RD_SCAN   = 2'd1,
    RD_REF    = 2'd2
  } rd_sel_t;

  typedef enum logic [2:0] {
    REF_HOLD    = 3'd0,
    REF_LOAD_LO = 3'd1,
    REF_LOAD_HI = 3'd2,
    REF_INC     = 3'd3,
    REF_DEC     = 3'd4
  } ref_op_t;

  typedef struct packed {
    logic    acc_en;
    logic    clr_en;
    logic    idx_zero;
    logic    scan_start;
    logic    scan_dir;
    rd_sel_t rd_sel;
    ref_op_t ref_op;
    logic    cap_lo;
    logic    cap_hi;
    logic    out_load;
  } hpr_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic clr_last;
    logic lo_go;
    logic hi_go;
    logic sparse;
    logic out_free;
  } hpr_sts_t;

endpackage

`default_nettype wire

@@ rtl/hpr_ctrl.sv @@
// hpr_ctrl: frame sequencer for the histogram percentile range block
// accumulate, percentile scans, sparse-bin refinement, result load, clear
// depends on hpr_pkg
`default_nettype none

module hpr_ctrl import hpr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_ready,
  input  wire hpr_sts_t sts_i,
  output hpr_cmd_t      cmd_o
);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_ACCUM   = 11'b000_0000_0010,
    S_DRAIN   = 11'b000_0000_0100,
    S_LSCAN   = 11'b000_0000_1000,
    S_HSTART  = 11'b000_0001_0000,
    S_HSCAN   = 11'b000_0010_0000,
    S_RLO_CHK = 11'b000_0100_0000,
    S_RLO_TST = 11'b000_1000_0000,
    S_RHI_CHK = 11'b001_0000_0000,
    S_RHI_TST = 11'b010_0000_0000,
    S_OUT     = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel = RD_SCAN;
    cmd_o.ref_op = REF_HOLD;
    unique case (state_r)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_nxt = S_ACCUM;
        end
      end
      S_ACCUM: begin
        in_ready     = 1'b1;
        cmd_o.rd_sel = RD_SAMPLE;
        cmd_o.acc_en = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.scan_start = 1'b1;
        cmd_o.scan_dir   = 1'b0;
        state_nxt        = S_LSCAN;
      end
      S_LSCAN: begin
        if (sts_i.scan_done) begin
          state_nxt = S_HSTART;
        end
      end
      S_HSTART: begin
        cmd_o.scan_start = 1'b1;
        cmd_o.scan_dir   = 1'b1;
        state_nxt        = S_HSCAN;
      end
      S_HSCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.ref_op = REF_LOAD_LO;
          state_nxt    = S_RLO_CHK;
        end
      end
      S_RLO_CHK: begin
        cmd_o.rd_sel = RD_REF;
        if (!sts_i.lo_go) begin
          cmd_o.cap_lo = 1'b1;
          cmd_o.ref_op = REF_LOAD_HI;
          state_nxt    = S_RHI_CHK;
        end else begin
          state_nxt = S_RLO_TST;
        end
      end
      S_RLO_TST: begin
        cmd_o.rd_sel = RD_REF;
        if (sts_i.sparse) begin
          cmd_o.ref_op = REF_INC;
          state_nxt    = S_RLO_CHK;
        end else begin
          cmd_o.cap_lo = 1'b1;
          cmd_o.ref_op = REF_LOAD_HI;
          state_nxt    = S_RHI_CHK;
        end
      end
      S_RHI_CHK: begin
        cmd_o.rd_sel = RD_REF;
        if (!sts_i.hi_go) begin
          cmd_o.cap_hi = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_RHI_TST;
        end
      end
      S_RHI_TST: begin
        cmd_o.rd_sel = RD_REF;
        if (sts_i.sparse) begin
          cmd_o.ref_op = REF_DEC;
          state_nxt    = S_RHI_CHK;
        end else begin
          cmd_o.cap_hi = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.idx_zero = 1'b1;
          state_nxt      = S_CLEAR;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/hpr_datapath.sv @@
// hpr_datapath: bin memory, sample counting, percentile scan pipeline,
// refinement index, config registers and result register
// depends on hpr_pkg
`default_nettype none

module hpr_datapath import hpr_pkg::*; #(
  parameter int BIN_COUNT   = 4096,
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire hpr_cmd_t                cmd_i,
  output hpr_sts_t                     sts_o,
  input  wire logic [SAMPLE_W-1:0]     in_sample,
  input  wire logic                    cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [LOW_LEVEL_W-1:0]       out_low_level,
  output logic [HIGH_LEVEL_W-1:0]      out_high_level
);

  localparam int BIN_W = $clog2(BIN_COUNT);
  localparam int TP_W  = COUNT_WIDTH + PCT_W;
  localparam int ACC_W = COUNT_WIDTH + BIN_W + PCT_W;
  localparam logic [BIN_W-1:0]   TOP_BIN  = BIN_W'(BIN_COUNT - 1);
  localparam logic [BIN_W:0]     NO_LOW   = (BIN_W + 1)'(BIN_COUNT);
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  // config registers
  logic [PCT_W-1:0]   lo_pct_r, hi_pct_r;
  logic [LIMIT_W-1:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_pct_r <= LOW_PCT_RST;
      hi_pct_r <= HIGH_PCT_RST;
      lim_r    <= SPARSE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOW_PCT:  lo_pct_r <= cfg_data[PCT_W-1:0];
        CFG_HIGH_PCT: hi_pct_r <= cfg_data[PCT_W-1:0];
        CFG_SPARSE:   lim_r    <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sample to bin
  logic [31:0]      raw_bin;
  logic [BIN_W-1:0] smp_bin;

  assign raw_bin = 32'(in_sample) >> BIN_SHIFT;
  assign smp_bin = (raw_bin > 32'(BIN_COUNT - 1)) ? TOP_BIN : raw_bin[BIN_W-1:0];

  // bin memory
  logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [BIN_W-1:0]       rd_addr, wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic                   wr_en;

  logic [BIN_W-1:0] idx_r;
  logic [BIN_W:0]   ri_r;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_SAMPLE: rd_addr = smp_bin;
      RD_SCAN:   rd_addr = idx_r;
      RD_REF:    rd_addr = ri_r[BIN_W-1:0];
      default:   rd_addr = smp_bin;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // count update with forwarding from the previous write
  logic                   upd_vld_r, fwd_vld_r;
  logic [BIN_W-1:0]       upd_bin_r, fwd_bin_r;
  logic [COUNT_WIDTH-1:0] fwd_val_r, cur_cnt, new_cnt;
  logic [COUNT_WIDTH-1:0] tot_r;

  assign cur_cnt = (fwd_vld_r && (fwd_bin_r == upd_bin_r)) ? fwd_val_r : rd_data_r;
  assign new_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + CNT_ONE;

  always_comb begin
    if (cmd_i.clr_en) begin
      wr_en   = 1'b1;
      wr_addr = idx_r;
      wr_data = '0;
    end else begin
      wr_en   = upd_vld_r;
      wr_addr = upd_bin_r;
      wr_data = new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_vld_r <= 1'b0;
      fwd_vld_r <= 1'b0;
      tot_r     <= '0;
    end else begin
      upd_vld_r <= cmd_i.acc_en;
      fwd_vld_r <= upd_vld_r;
      if (cmd_i.clr_en) begin
        tot_r <= '0;
      end else if (cmd_i.acc_en && (tot_r != '1)) begin
        tot_r <= tot_r + CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    upd_bin_r <= smp_bin;
    fwd_bin_r <= upd_bin_r;
    fwd_val_r <= new_cnt;
  end

  // percentile scan pipeline: read, scale, accumulate, compare
  logic             run_r, dir_r;
  logic             rd_vld_r, scl_vld_r, acc_vld_r;
  logic             rd_end_r, scl_end_r, acc_end_r;
  logic [BIN_W-1:0] rd_idx_r, scl_idx_r, acc_idx_r;
  logic [ACC_W-1:0] scl_r, acc_r, scaled;
  logic [TP_W-1:0]  tp_r;
  logic [BIN_W-1:0] scan_end;
  logic             at_end, hit, done;
  logic [BIN_W:0]   lo_r;
  logic [BIN_W-1:0] hi_r;

  assign scan_end = dir_r ? BIN_W'(1) : TOP_BIN;
  assign at_end   = (idx_r == scan_end);
  assign scaled   = (ACC_W'(rd_data_r) << SCALE_SH_A) + (ACC_W'(rd_data_r) << SCALE_SH_B)
                  + (ACC_W'(rd_data_r) << SCALE_SH_C);
  assign hit      = acc_vld_r && (acc_r > ACC_W'(tp_r));
  assign done     = acc_vld_r && (hit || acc_end_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      run_r     <= 1'b0;
      dir_r     <= 1'b0;
      rd_vld_r  <= 1'b0;
      scl_vld_r <= 1'b0;
      acc_vld_r <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        idx_r <= cmd_i.scan_dir ? TOP_BIN : '0;
      end else if (cmd_i.idx_zero) begin
        idx_r <= '0;
      end else if (cmd_i.clr_en) begin
        idx_r <= idx_r + BIN_W'(1);
      end else if (run_r && !at_end) begin
        idx_r <= dir_r ? idx_r - BIN_W'(1) : idx_r + BIN_W'(1);
      end

      if (cmd_i.scan_start) begin
        dir_r <= cmd_i.scan_dir;
      end

      if (cmd_i.scan_start) begin
        run_r <= 1'b1;
      end else if (done || at_end) begin
        run_r <= 1'b0;
      end

      if (cmd_i.scan_start || done) begin
        rd_vld_r  <= 1'b0;
        scl_vld_r <= 1'b0;
        acc_vld_r <= 1'b0;
      end else begin
        rd_vld_r  <= run_r;
        scl_vld_r <= rd_vld_r;
        acc_vld_r <= scl_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= idx_r;
    rd_end_r  <= at_end;
    scl_idx_r <= rd_idx_r;
    scl_end_r <= rd_end_r;
    scl_r     <= scaled;
    acc_idx_r <= scl_idx_r;
    acc_end_r <= scl_end_r;
    if (cmd_i.scan_start) begin
      acc_r <= '0;
      tp_r  <= TP_W'(tot_r) * TP_W'(cmd_i.scan_dir ? hi_pct_r : lo_pct_r);
    end else if (scl_vld_r) begin
      acc_r <= acc_r + scl_r;
    end
    if (done && !dir_r) begin
      lo_r <= hit ? {1'b0, acc_idx_r} : NO_LOW;
    end
    if (done && dir_r) begin
      hi_r <= hit ? acc_idx_r : '0;
    end
  end

  // refinement index and captured bounds
  logic [BIN_W:0]   res_lo_r;
  logic [BIN_W-1:0] res_hi_r;

  always_ff @(posedge clk) begin
    unique case (cmd_i.ref_op)
      REF_HOLD:    ri_r <= ri_r;
      REF_LOAD_LO: ri_r <= lo_r;
      REF_LOAD_HI: ri_r <= {1'b0, hi_r};
      REF_INC:     ri_r <= ri_r + (BIN_W + 1)'(1);
      REF_DEC:     ri_r <= ri_r - (BIN_W + 1)'(1);
      default:     ri_r <= ri_r;
    endcase
    if (cmd_i.cap_lo) begin
      res_lo_r <= ri_r;
    end
    if (cmd_i.cap_hi) begin
      res_hi_r <= ri_r[BIN_W-1:0];
    end
  end

  // result register
  logic                    out_valid_r;
  logic [LOW_LEVEL_W-1:0]  out_lo_r;
  logic [HIGH_LEVEL_W-1:0] out_hi_r;
  logic [31:0]             lvl_lo, lvl_hi;

  assign lvl_lo = 32'(res_lo_r) << BIN_SHIFT;
  assign lvl_hi = 32'(res_hi_r) << BIN_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_lo_r <= lvl_lo[LOW_LEVEL_W-1:0];
      out_hi_r <= lvl_hi[HIGH_LEVEL_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_low_level  = out_lo_r;
  assign out_high_level = out_hi_r;

  always_comb begin
    sts_o.scan_done = done;
    sts_o.clr_last  = (idx_r == TOP_BIN);
    sts_o.lo_go     = (ri_r < {1'b0, hi_r});
    sts_o.hi_go     = (ri_r > lo_r);
    sts_o.sparse    = (rd_data_r < COUNT_WIDTH'(lim_r));
    sts_o.out_free  = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

@@ rtl/histogram_percentile_range_core.sv @@
// throughput: one sample word per cycle while a frame is being counted
// frame end: a low percentile scan upward and a high percentile scan downward over the bin memory,
//   then refinement stepping bin by bin past sparse bins, then a clear pass over every bin
// the path from last sample to result runs through the scans and refinement, which share one memory read port
// reset (synchronous, active low): config to defaults, then a clear pass over every bin
//   with in_ready low; config writes are taken whenever reset is not asserted
`default_nettype none

module histogram_percentile_range_core import hpr_pkg::*; #(
  parameter int BIN_COUNT   = 4096,
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [SAMPLE_W-1:0]     in_sample,
  input  wire logic                    in_last,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [LOW_LEVEL_W-1:0]       out_low_level,
  output logic [HIGH_LEVEL_W-1:0]      out_high_level,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  hpr_cmd_t cmd;
  hpr_sts_t sts;

  assign cfg_ready = 1'b1;

  hpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  hpr_datapath #(
    .BIN_COUNT   (BIN_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_sample      (in_sample),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_low_level  (out_low_level),
    .out_high_level (out_high_level)
  );

endmodule

`default_nettype wire

@@ rtl/hpr_checker.sv @@
// hpr_checker: port-level assertions for histogram_percentile_range_core
// attached by the bind at the end of this file; depends on hpr_pkg
`default_nettype none

module hpr_checker import hpr_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    in_last,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [LOW_LEVEL_W-1:0]  out_low_level,
  input wire logic [HIGH_LEVEL_W-1:0] out_high_level
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_low_level) && $stable(out_high_level))
    else $error("result word changed while stalled");

  // frame end stops intake
  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("sample taken right after frame end");

  // a new result appears only while intake is closed
  a_rose_closed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_ready)
    else $error("result appeared during sample intake");

  // levels are whole bins
  a_bin_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_low_level[3:0] == 4'd0) && (out_high_level[3:0] == 4'd0))
    else $error("level not a multiple of the bin width");

  // reset closes both channels
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("channel open after reset");

endmodule

bind histogram_percentile_range_core hpr_checker u_hpr_checker (.*);

`default_nettype wire

@@ tb/histogram_percentile_range_core_tb.sv @@
// histogram_percentile_range_core_tb: self-checking bench for the percentile range core
// a bin tally kept in the bench predicts both levels per frame; directed and random frames
// depends on hpr_pkg and histogram_percentile_range_core
module histogram_percentile_range_core_tb;
  import hpr_pkg::*;

  localparam int BINS          = 4096;
  localparam int COUNT_W       = 24;
  localparam int IDLE_PCT      = 7;
  localparam int SETTLE_CYCLES = BINS + 64;
  localparam int QUIET_LIMIT   = 150000;
  localparam int RANDOM_WORDS  = 1500;
  localparam int PHASES        = 6;
  localparam int MAX_PRINTS    = 50;
  localparam longint unsigned FULL_SCALE = 64'd25600;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
  } pixel_t;

  typedef struct packed {
    logic [LOW_LEVEL_W-1:0]  low;
    logic [HIGH_LEVEL_W-1:0] high;
  } levels_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [SAMPLE_W-1:0]     in_sample = '0;
  logic                    in_last = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b1;
  logic [LOW_LEVEL_W-1:0]  out_low_level;
  logic [HIGH_LEVEL_W-1:0] out_high_level;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  logic [COUNT_W-1:0] bin_tally [BINS];
  logic [COUNT_W-1:0] sample_tally;
  logic [PCT_W-1:0]   low_pct;
  logic [PCT_W-1:0]   high_pct;
  logic [LIMIT_W-1:0] sparse_limit;

  pixel_t  word_feed [$];
  levels_t pending_levels [$];

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  bit   steady_run = 1'b0;
  int   quiet_cycles = 0;
  int   mismatch_count = 0;
  int   frames_seen = 0;
  int   words_taken = 0;
  int   reg_writes = 0;
  int   levels_checked = 0;

  histogram_percentile_range_core #(
    .BIN_COUNT   (BINS),
    .COUNT_WIDTH (COUNT_W)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_low_level  (out_low_level),
    .out_high_level (out_high_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  function automatic void clear_tally();
    for (int k = 0; k < BINS; k++) begin
      bin_tally[k] = '0;
    end
    sample_tally = '0;
  endfunction

  function automatic void write_shadow(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_LOW_PCT: begin
        low_pct = data[PCT_W-1:0];
      end
      CFG_HIGH_PCT: begin
        high_pct = data[PCT_W-1:0];
      end
      CFG_SPARSE: begin
        sparse_limit = data[LIMIT_W-1:0];
      end
      default: begin
      end
    endcase
    reg_writes++;
  endfunction

  function automatic levels_t frame_levels();
    longint unsigned run;
    longint unsigned low_bar;
    longint unsigned high_bar;
    int              lo;
    int              hi;
    int              k;
    bit              hi_hit;
    levels_t         lv;
    low_bar  = 64'(sample_tally) * 64'(low_pct);
    high_bar = 64'(sample_tally) * 64'(high_pct);
    lo  = BINS;
    run = 0;
    for (k = 0; k < BINS; k++) begin
      if (lo == BINS) begin
        run += 64'(bin_tally[k]);
        if (run * FULL_SCALE > low_bar) lo = k;
      end
    end
    hi     = 0;
    hi_hit = 1'b0;
    run    = 0;
    for (k = BINS - 1; k > 0; k--) begin
      if (!hi_hit) begin
        run += 64'(bin_tally[k]);
        if (run * FULL_SCALE > high_bar) begin
          hi     = k;
          hi_hit = 1'b1;
        end
      end
    end
    // pull both bounds inward past thinly populated bins
    k = lo;
    while (k < hi && bin_tally[k] < sparse_limit) k++;
    lv.low = LOW_LEVEL_W'(k << BIN_SHIFT);
    k = hi;
    while (k > lo && bin_tally[k] < sparse_limit) k--;
    lv.high = HIGH_LEVEL_W'(k << BIN_SHIFT);
    return lv;
  endfunction

  function automatic void tally_word(input logic [SAMPLE_W-1:0] s, input logic eof);
    int b;
    b = int'(s >> BIN_SHIFT);
    if (b > BINS - 1) b = BINS - 1;
    if (bin_tally[b] != '1) bin_tally[b] = bin_tally[b] + 1'b1;
    if (sample_tally != '1) sample_tally = sample_tally + 1'b1;
    words_taken++;
    if (eof) begin
      pending_levels.push_back(frame_levels());
      clear_tally();
      frames_seen++;
    end
  endfunction

  task automatic check_levels(input logic [LOW_LEVEL_W-1:0] got_low,
                              input logic [HIGH_LEVEL_W-1:0] got_high);
    levels_t want;
    if (pending_levels.size() == 0) begin
      report_mismatch($sformatf("result with no frame pending: low %0d high %0d",
                                got_low, got_high));
    end else begin
      want = pending_levels.pop_front();
      levels_checked++;
      if (got_low !== want.low) begin
        report_mismatch($sformatf("low_level got %0d want %0d", got_low, want.low));
      end
      if (got_high !== want.high) begin
        report_mismatch($sformatf("high_level got %0d want %0d", got_high, want.high));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken     <= 1'b0;
      cfg_taken    <= 1'b0;
      quiet_cycles <= 0;
      clear_tally();
      low_pct      = LOW_PCT_RST;
      high_pct     = HIGH_PCT_RST;
      sparse_limit = SPARSE_RST;
    end else begin
      in_taken  <= in_valid && in_ready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) write_shadow(cfg_index, cfg_data);
      if (in_valid && in_ready) tally_word(in_sample, in_last);
      if (out_valid && out_ready) check_levels(out_low_level, out_high_level);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(negedge clk) begin : feed_driver
    pixel_t w;
    if (rst_n) begin
      out_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
      if (!in_valid || in_taken) begin
        if (word_feed.size() != 0 && (steady_run || $urandom_range(99) >= IDLE_PCT)) begin
          w = word_feed.pop_front();
          in_valid  <= 1'b1;
          in_sample <= w.sample;
          in_last   <= w.frame_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
    $display("histogram_percentile_range_core regression: fail");
    $finish;
  end

  function automatic void push_word(input logic [SAMPLE_W-1:0] s, input logic eof);
    pixel_t w;
    w.sample    = s;
    w.frame_end = eof;
    word_feed.push_back(w);
  endfunction

  function automatic int queue_frame();
    int                  pick;
    int                  len;
    int                  flavor;
    int                  center;
    int                  spread;
    int                  v;
    logic [SAMPLE_W-1:0] hot [3];
    pick   = $urandom_range(9);
    len    = (pick < 6) ? $urandom_range(1, 30) :
             (pick < 9) ? $urandom_range(31, 80) : $urandom_range(100, 200);
    flavor = $urandom_range(3);
    center = $urandom_range(65535);
    spread = $urandom_range(1, 4095);
    for (int h = 0; h < 3; h++) begin
      hot[h] = SAMPLE_W'($urandom_range(65535));
    end
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(19) == 0) begin
        v = $urandom_range(65535);
      end else begin
        case (flavor)
          0: begin
            v = center + int'($urandom_range(2 * spread)) - spread;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
          end
          1: begin
            v = $urandom_range(65535);
          end
          2: begin
            v = hot[$urandom_range(2)];
          end
          default: begin
            v = $urandom_range(1) ? $urandom_range(15) : 65535 - $urandom_range(15);
          end
        endcase
      end
      push_word(SAMPLE_W'(v), k == len - 1);
    end
    return len;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain(input bit settle);
    while (word_feed.size() != 0 || in_valid) @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int made;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: one-word frames at both ends, then a small mixed frame
    push_word(16'h0000, 1'b1);
    push_word(16'hFFFF, 1'b1);
    push_word(16'h0000, 1'b0);
    push_word(16'hFFFF, 1'b0);
    push_word(16'h8000, 1'b0);
    push_word(16'h8008, 1'b0);
    push_word(16'h800F, 1'b1);
    drain(1'b1);

    write_reg(CFG_LOW_PCT, 0);
    write_reg(CFG_HIGH_PCT, 0);
    write_reg(CFG_SPARSE, 0);
    push_word(16'h1234, 1'b0);
    push_word(16'h000F, 1'b0);
    push_word(16'hABCD, 1'b1);
    drain(1'b1);

    // shares above 100 percent never pass; sparse data gets masked to 255
    write_reg(CFG_LOW_PCT, 32767);
    write_reg(CFG_HIGH_PCT, 32767);
    write_reg(CFG_SPARSE, 32767);
    push_word(16'h5555, 1'b0);
    push_word(16'hAAAA, 1'b0);
    push_word(16'h7FF0, 1'b1);
    drain(1'b1);

    write_reg(CFG_UNUSED, 16'h0155);
    write_reg(CFG_LOW_PCT, 25599);
    write_reg(CFG_HIGH_PCT, 25599);
    write_reg(CFG_SPARSE, 1);
    for (int k = 0; k < 8; k++) begin
      push_word(16'h4440, 1'b0);
    end
    push_word(16'h0010, 1'b0);
    push_word(16'hFFF0, 1'b1);
    drain(1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_LOW_PCT, $urandom_range(2560));
          write_reg(CFG_HIGH_PCT, $urandom_range(2560));
          write_reg(CFG_SPARSE, $urandom_range(20));
        end
        1: begin
          write_reg(CFG_LOW_PCT, 0);
          write_reg(CFG_HIGH_PCT, 25599);
          write_reg(CFG_SPARSE, 255);
        end
        2: begin
          write_reg(CFG_LOW_PCT, 25599);
          write_reg(CFG_HIGH_PCT, 0);
          write_reg(CFG_SPARSE, 0);
        end
        3: begin
          write_reg(CFG_LOW_PCT, $urandom_range(12800));
          write_reg(CFG_HIGH_PCT, 25600);
          write_reg(CFG_SPARSE, $urandom_range(255));
        end
        4: begin
          write_reg(CFG_LOW_PCT, $urandom_range(32767));
          write_reg(CFG_HIGH_PCT, $urandom_range(32767));
          write_reg(CFG_SPARSE, $urandom_range(32767));
        end
        default: begin
          write_reg(CFG_UNUSED, $urandom_range(32767));
          write_reg(CFG_LOW_PCT, $urandom_range(256, 6400));
          write_reg(CFG_HIGH_PCT, $urandom_range(256, 6400));
          write_reg(CFG_SPARSE, 10);
        end
      endcase
      steady_run = (phase == 2);
      made = 0;
      while (made < RANDOM_WORDS / PHASES) begin
        made += queue_frame();
        if ($urandom_range(9) == 0) drain(1'b0);
      end
      drain(1'b1);
    end
    steady_run = 1'b0;

    if (pending_levels.size() != 0) begin
      report_mismatch($sformatf("%0d frames never produced levels", pending_levels.size()));
    end
    $display("covered %0d frames of %0d sample words over %0d register writes",
             frames_seen, words_taken, reg_writes);
    $display("compared %0d level pairs, %0d mismatches", levels_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("histogram_percentile_range_core regression: pass");
    end else begin
      $display("histogram_percentile_range_core regression: fail");
    end
    $finish;
  end

endmodule
